// ----- hw/rtl/square_noise_sound_generator_top_defines.svh -----
// Assertion macros for the sound generator port checker.
`ifndef SQUARE_NOISE_SOUND_GENERATOR_TOP_DEFINES_SVH
`define SQUARE_NOISE_SOUND_GENERATOR_TOP_DEFINES_SVH

// Clocked assertion, quiet while reset is held.
`define SNG_ASSERT_RST(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("sound generator port check failed");

// Clocked assertion, checked on every edge.
`define SNG_ASSERT_CLK(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("sound generator port check failed");

`endif

// ----- hw/rtl/sngen_pkg.sv -----
// Types, constants and level table of the square/noise sound generator.
package sngen_pkg;

    localparam int TONE_CH    = 3;
    localparam int VOICES     = TONE_CH + 1;
    localparam int NOISE_V    = TONE_CH;
    localparam int CMD_DEPTH  = 2;
    localparam int OUT_DEPTH  = 2;

    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_MONO  = 2'd1;
    localparam logic [1:0] MODE_LEFT  = 2'd2;
    localparam logic [1:0] MODE_RIGHT = 2'd3;

    localparam logic [1:0] REG_TONE2 = 2'd2;
    localparam logic [1:0] REG_NOISE = 2'd3;

    localparam logic [1:0] CFG_VARIANT = 2'd0;
    localparam logic [1:0] CFG_OUT_EN  = 2'd1;
    localparam logic [1:0] CFG_CH_EN   = 2'd2;

    localparam logic [1:0] RATE_16  = 2'd0;
    localparam logic [1:0] RATE_32  = 2'd1;
    localparam logic [1:0] RATE_64  = 2'd2;
    localparam logic [1:0] RATE_T2  = 2'd3;

    localparam logic [9:0]  NOISE_PER_16 = 10'h010;
    localparam logic [9:0]  NOISE_PER_32 = 10'h020;
    localparam logic [9:0]  NOISE_PER_64 = 10'h040;
    localparam logic [15:0] SEED_MONO    = 16'h8000;
    localparam logic [15:0] SEED_STEREO  = 16'h4000;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_TICK,
        OP_ATT_L,
        OP_ATT_R,
        OP_TPER_LO,
        OP_TPER_HI,
        OP_NPER_LO,
        OP_NPER_HI,
        OP_NCTL_MONO,
        OP_NCTL_STEREO
    } t_op;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] data;
        logic       debug_mix;
    } t_in_word;

    typedef struct packed {
        logic signed [15:0] left_sample;
        logic signed [15:0] right_sample;
    } t_out_word;

    typedef struct packed {
        t_op        op;
        logic [1:0] sel;
        logic [5:0] arg;
        logic       debug_mix;
    } t_cmd;

    typedef struct packed {
        logic [VOICES-1:0]       pol;
        logic [VOICES-1:0][3:0]  att_l;
        logic [VOICES-1:0][3:0]  att_r;
        logic [VOICES-1:0]       ch_en;
        logic                    mix_en;
    } t_mix_in;

    function automatic logic [12:0] level(input logic [3:0] att);
        logic [12:0] lv;
        unique case (att)
            4'd0:  lv = 13'd8191;
            4'd1:  lv = 13'd6507;
            4'd2:  lv = 13'd5168;
            4'd3:  lv = 13'd4105;
            4'd4:  lv = 13'd3261;
            4'd5:  lv = 13'd2590;
            4'd6:  lv = 13'd2057;
            4'd7:  lv = 13'd1642;
            4'd8:  lv = 13'd1298;
            4'd9:  lv = 13'd1031;
            4'd10: lv = 13'd819;
            4'd11: lv = 13'd650;
            4'd12: lv = 13'd516;
            4'd13: lv = 13'd410;
            4'd14: lv = 13'd326;
            4'd15: lv = 13'd0;
        endcase
        return lv;
    endfunction

endpackage

// ----- hw/rtl/sngen_mix.sv -----
// Signed left/right mixer over the four voices.
module sngen_mix (
    input  sngen_pkg::t_mix_in   i_mix,
    output sngen_pkg::t_out_word o_word
);

    logic signed [15:0] sum_l;
    logic signed [15:0] sum_r;
    logic signed [15:0] lv_l;
    logic signed [15:0] lv_r;

    always_comb begin
        sum_l = '0;
        sum_r = '0;
        lv_l  = '0;
        lv_r  = '0;
        for (int v = 0; v < sngen_pkg::VOICES; v++) begin
            lv_l = signed'({3'b000, sngen_pkg::level(i_mix.att_l[v])});
            lv_r = signed'({3'b000, sngen_pkg::level(i_mix.att_r[v])});
            if (i_mix.mix_en && i_mix.ch_en[v]) begin
                sum_l = i_mix.pol[v] ? sum_l + lv_l : sum_l - lv_l;
                sum_r = i_mix.pol[v] ? sum_r + lv_r : sum_r - lv_r;
            end
        end
        o_word.left_sample  = sum_l;
        o_word.right_sample = sum_r;
    end

endmodule

// ----- hw/rtl/sngen_front.sv -----
// Front end: takes input words, resolves the latched register, queues commands.
module sngen_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    output logic                o_full,
    input  sngen_pkg::t_in_word i_in_word,
    output logic                o_cmd_valid,
    input  logic                i_cmd_take,
    output sngen_pkg::t_cmd     o_cmd
);

    localparam int PTR_W = $clog2(sngen_pkg::CMD_DEPTH);
    localparam int CNT_W = $clog2(sngen_pkg::CMD_DEPTH + 1);

    sngen_pkg::t_cmd   r_q [sngen_pkg::CMD_DEPTH];
    logic [PTR_W-1:0]  r_wp, n_wp;
    logic [PTR_W-1:0]  r_rp, n_rp;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [1:0]        r_lreg, n_lreg;
    logic              r_lkind, n_lkind;

    sngen_pkg::t_cmd   cmd_dec;
    logic              wr;
    logic              rd;
    logic              latch;
    logic [1:0]        eff_reg;
    logic              eff_kind;
    logic [1:0]        mode;

    assign o_full      = (r_cnt == CNT_W'(sngen_pkg::CMD_DEPTH));
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rp];
    assign wr          = i_push && !o_full;
    assign rd          = i_cmd_take && o_cmd_valid;

    assign mode     = i_in_word.mode;
    assign latch    = i_in_word.data[7];
    assign eff_reg  = latch ? i_in_word.data[6:5] : r_lreg;
    assign eff_kind = latch ? i_in_word.data[4] : r_lkind;

    always_comb begin
        cmd_dec.op        = sngen_pkg::OP_NOP;
        cmd_dec.sel       = eff_reg;
        cmd_dec.arg       = i_in_word.data[5:0];
        cmd_dec.debug_mix = i_in_word.debug_mix;
        if (mode == sngen_pkg::MODE_TICK) begin
            cmd_dec.op = sngen_pkg::OP_TICK;
        end else if (latch) begin
            if (eff_kind) begin
                cmd_dec.op = (mode == sngen_pkg::MODE_RIGHT) ? sngen_pkg::OP_ATT_R
                                                             : sngen_pkg::OP_ATT_L;
            end else if (mode == sngen_pkg::MODE_RIGHT) begin
                if (eff_reg == sngen_pkg::REG_TONE2) begin
                    cmd_dec.op = sngen_pkg::OP_NPER_LO;
                end else if (eff_reg == sngen_pkg::REG_NOISE) begin
                    cmd_dec.op = sngen_pkg::OP_NCTL_STEREO;
                end
            end else if (eff_reg != sngen_pkg::REG_NOISE) begin
                cmd_dec.op = sngen_pkg::OP_TPER_LO;
            end else if (mode == sngen_pkg::MODE_MONO) begin
                cmd_dec.op = sngen_pkg::OP_NCTL_MONO;
            end
        end else if (mode == sngen_pkg::MODE_MONO) begin
            if (eff_kind) begin
                cmd_dec.op = sngen_pkg::OP_ATT_L;
            end else if (eff_reg != sngen_pkg::REG_NOISE) begin
                cmd_dec.op = sngen_pkg::OP_TPER_HI;
            end else begin
                cmd_dec.op = sngen_pkg::OP_NCTL_MONO;
            end
        end else if (mode == sngen_pkg::MODE_LEFT) begin
            if (!eff_kind && eff_reg != sngen_pkg::REG_NOISE) begin
                cmd_dec.op = sngen_pkg::OP_TPER_HI;
            end
        end else begin
            if (!eff_kind && eff_reg == sngen_pkg::REG_TONE2) begin
                cmd_dec.op = sngen_pkg::OP_NPER_HI;
            end
        end
    end

    // pointers wrap naturally, depth is a power of two
    always_comb begin
        n_wp    = wr ? r_wp + 1'b1 : r_wp;
        n_rp    = rd ? r_rp + 1'b1 : r_rp;
        n_cnt   = r_cnt;
        n_lreg  = r_lreg;
        n_lkind = r_lkind;
        if (wr && !rd) begin
            n_cnt = r_cnt + 1'b1;
        end else if (rd && !wr) begin
            n_cnt = r_cnt - 1'b1;
        end
        if (wr && mode != sngen_pkg::MODE_TICK && latch) begin
            n_lreg  = eff_reg;
            n_lkind = eff_kind;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_cnt   <= '0;
            r_lreg  <= '0;
            r_lkind <= 1'b0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_cnt   <= n_cnt;
            r_lreg  <= n_lreg;
            r_lkind <= n_lkind;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_q[r_wp] <= cmd_dec;
        end
    end

endmodule

// ----- hw/rtl/sngen_back.sv -----
// Back end: voice state, tick and register updates, mix and result queue.
module sngen_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_index,
    input  logic [3:0]           i_cfg_data,
    input  logic                 i_cmd_valid,
    input  sngen_pkg::t_cmd      i_cmd,
    output logic                 o_cmd_take,
    output logic                 o_empty,
    input  logic                 i_pop,
    output sngen_pkg::t_out_word o_out_word
);

    localparam int VC    = sngen_pkg::VOICES;
    localparam int TC    = sngen_pkg::TONE_CH;
    localparam int PTR_W = $clog2(sngen_pkg::OUT_DEPTH);
    localparam int CNT_W = $clog2(sngen_pkg::OUT_DEPTH + 1);

    logic                   r_variant, n_variant;
    logic                   r_out_en, n_out_en;
    logic [VC-1:0]          r_ch_en, n_ch_en;
    logic [VC-1:0]          r_pol, n_pol;
    logic [VC-1:0][3:0]     r_att_l, n_att_l;
    logic [VC-1:0][3:0]     r_att_r, n_att_r;
    logic [TC-1:0][9:0]     r_tper, n_tper;
    logic [TC-1:0][9:0]     r_tcnt, n_tcnt;
    logic [11:0]            r_ncnt, n_ncnt;
    logic [9:0]             r_nper, n_nper;
    logic [15:0]            r_sr, n_sr;
    logic [1:0]             r_rate, n_rate;
    logic                   r_white, n_white;
    logic                   r_half, n_half;

    sngen_pkg::t_out_word   r_oq [sngen_pkg::OUT_DEPTH];
    logic [PTR_W-1:0]       r_owp, n_owp;
    logic [PTR_W-1:0]       r_orp, n_orp;
    logic [CNT_W-1:0]       r_ocnt, n_ocnt;

    logic                   go;
    logic                   pop_ok;
    logic [9:0]             noise_per;
    logic                   fb_m;
    logic                   fb_s;
    logic [TC-1:0][9:0]     tdec;
    sngen_pkg::t_mix_in     mix_in;
    sngen_pkg::t_out_word   mix_word;

    assign o_cmd_take = (r_ocnt != CNT_W'(sngen_pkg::OUT_DEPTH)) || i_pop;
    assign go         = i_cmd_valid && o_cmd_take;
    assign o_empty    = (r_ocnt == '0);
    assign pop_ok     = i_pop && !o_empty;
    assign o_out_word = r_oq[r_orp];

    assign fb_m = r_white ? ~(r_sr[0] ^ r_sr[3]) : r_sr[0];
    assign fb_s = r_sr[0] ^ (r_sr[2] & r_white);

    always_comb begin
        unique case (r_rate)
            sngen_pkg::RATE_16: noise_per = sngen_pkg::NOISE_PER_16;
            sngen_pkg::RATE_32: noise_per = sngen_pkg::NOISE_PER_32;
            sngen_pkg::RATE_64: noise_per = sngen_pkg::NOISE_PER_64;
            sngen_pkg::RATE_T2: noise_per = r_variant ? r_nper : r_tper[TC-1];
        endcase
        for (int t = 0; t < TC; t++) begin
            tdec[t] = (r_tcnt[t] != '0) ? r_tcnt[t] - 10'd1 : r_tcnt[t];
        end
    end

    always_comb begin
        n_variant = r_variant;
        n_out_en  = r_out_en;
        n_ch_en   = r_ch_en;
        n_pol     = r_pol;
        n_att_l   = r_att_l;
        n_att_r   = r_att_r;
        n_tper    = r_tper;
        n_tcnt    = r_tcnt;
        n_ncnt    = r_ncnt;
        n_nper    = r_nper;
        n_sr      = r_sr;
        n_rate    = r_rate;
        n_white   = r_white;
        n_half    = r_half;
        if (go) begin
            unique case (i_cmd.op)
                sngen_pkg::OP_TICK: begin
                    // noise steps first, then the tones
                    if (r_ncnt > 12'd1) begin
                        n_ncnt = r_ncnt - 12'd1;
                    end else begin
                        if (r_ncnt == '0 && noise_per == '0) begin
                            n_ncnt = '0;
                        end else begin
                            n_ncnt = {2'b00, noise_per} + r_ncnt - 12'd1;
                        end
                        n_half = ~r_half;
                        if (!r_half) begin
                            if (r_variant) begin
                                n_pol[sngen_pkg::NOISE_V] = ~r_sr[0];
                                n_sr = {1'b0, r_sr[15] | fb_s, r_sr[14:1]};
                            end else begin
                                n_pol[sngen_pkg::NOISE_V] = r_sr[0];
                                n_sr = {fb_m, r_sr[15:1]};
                            end
                        end
                    end
                    for (int t = 0; t < TC; t++) begin
                        if (tdec[t] == '0) begin
                            n_tcnt[t] = r_tper[t];
                            if (r_tper[t] != '0) begin
                                n_pol[t] = ~r_pol[t];
                            end
                        end else begin
                            n_tcnt[t] = tdec[t];
                        end
                    end
                end
                sngen_pkg::OP_ATT_L:   n_att_l[i_cmd.sel] = i_cmd.arg[3:0];
                sngen_pkg::OP_ATT_R:   n_att_r[i_cmd.sel] = i_cmd.arg[3:0];
                sngen_pkg::OP_TPER_LO: n_tper[i_cmd.sel][3:0] = i_cmd.arg[3:0];
                sngen_pkg::OP_TPER_HI: n_tper[i_cmd.sel][9:4] = i_cmd.arg;
                sngen_pkg::OP_NPER_LO: n_nper[3:0] = i_cmd.arg[3:0];
                sngen_pkg::OP_NPER_HI: n_nper[9:4] = i_cmd.arg;
                sngen_pkg::OP_NCTL_MONO: begin
                    n_sr    = sngen_pkg::SEED_MONO;
                    n_rate  = i_cmd.arg[1:0];
                    n_white = i_cmd.arg[2];
                end
                sngen_pkg::OP_NCTL_STEREO: begin
                    n_sr    = sngen_pkg::SEED_STEREO;
                    n_rate  = i_cmd.arg[1:0];
                    n_white = i_cmd.arg[2];
                end
                sngen_pkg::OP_NOP: ;
                default: ;
            endcase
        end
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                sngen_pkg::CFG_VARIANT: begin
                    n_variant = i_cfg_data[0];
                    n_sr = i_cfg_data[0] ? sngen_pkg::SEED_STEREO : sngen_pkg::SEED_MONO;
                end
                sngen_pkg::CFG_OUT_EN: n_out_en = i_cfg_data[0];
                sngen_pkg::CFG_CH_EN:  n_ch_en  = i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        mix_in.pol    = n_pol;
        mix_in.att_l  = n_att_l;
        mix_in.att_r  = n_att_r;
        mix_in.ch_en  = r_ch_en;
        mix_in.mix_en = r_out_en || i_cmd.debug_mix;
    end

    sngen_mix u_mix (
        .i_mix  (mix_in),
        .o_word (mix_word)
    );

    always_comb begin
        n_owp  = go ? r_owp + 1'b1 : r_owp;
        n_orp  = pop_ok ? r_orp + 1'b1 : r_orp;
        n_ocnt = r_ocnt;
        if (go && !pop_ok) begin
            n_ocnt = r_ocnt + 1'b1;
        end else if (pop_ok && !go) begin
            n_ocnt = r_ocnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_variant <= 1'b0;
            r_out_en  <= 1'b1;
            r_ch_en   <= '1;
            r_pol     <= '1;
            r_att_l   <= '1;
            r_att_r   <= '1;
            r_tper    <= '0;
            r_tcnt    <= '0;
            r_ncnt    <= '0;
            r_nper    <= '0;
            r_sr      <= sngen_pkg::SEED_MONO;
            r_rate    <= '0;
            r_white   <= 1'b0;
            r_half    <= 1'b0;
            r_owp     <= '0;
            r_orp     <= '0;
            r_ocnt    <= '0;
        end else begin
            r_variant <= n_variant;
            r_out_en  <= n_out_en;
            r_ch_en   <= n_ch_en;
            r_pol     <= n_pol;
            r_att_l   <= n_att_l;
            r_att_r   <= n_att_r;
            r_tper    <= n_tper;
            r_tcnt    <= n_tcnt;
            r_ncnt    <= n_ncnt;
            r_nper    <= n_nper;
            r_sr      <= n_sr;
            r_rate    <= n_rate;
            r_white   <= n_white;
            r_half    <= n_half;
            r_owp     <= n_owp;
            r_orp     <= n_orp;
            r_ocnt    <= n_ocnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_oq[r_owp] <= mix_word;
        end
    end

endmodule

// ----- hw/rtl/square_noise_sound_generator_top.sv -----
// Top level of the three-tone plus noise sound generator.
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------
//  input    | push / full          | i_in_word (mode, data, debug_mix)
//  result   | pop / empty          | o_out_word (left, right sample)
//  config   | i_cfg_valid / ready  | i_cfg_index, i_cfg_data
//
// One word per cycle sustained while results are popped; a word passes the command queue
// and then the result queue. The back end update, which also forms the mix, sets the rate.
// Reset is synchronous and clears all voice state and both queues.
// Two-word command and result queues let either side stall; full rises only when both fill.
module square_noise_sound_generator_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  sngen_pkg::t_in_word  i_in_word,
    output logic                 empty,
    input  logic                 pop,
    output sngen_pkg::t_out_word o_out_word,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [1:0]           i_cfg_index,
    input  logic [3:0]           i_cfg_data
);

    logic            cmd_valid;
    logic            cmd_take;
    sngen_pkg::t_cmd cmd;

    assign o_cfg_ready = 1'b1;

    sngen_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_in_word   (i_in_word),
        .o_cmd_valid (cmd_valid),
        .i_cmd_take  (cmd_take),
        .o_cmd       (cmd)
    );

    sngen_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_take  (cmd_take),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_out_word  (o_out_word)
    );

endmodule

// ----- hw/rtl/sngen_checker.sv -----
// Port-level checker for the sound generator, bound to the top level.
`include "square_noise_sound_generator_top_defines.svh"

module sngen_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_full,
    input logic                 i_empty,
    input logic                 i_pop,
    input sngen_pkg::t_out_word i_out_word,
    input logic                 i_cfg_ready
);

    logic l_in_range;
    logic r_in_range;

    assign l_in_range = (i_out_word.left_sample >= -16'sd32764) &&
                        (i_out_word.left_sample <= 16'sd32764);
    assign r_in_range = (i_out_word.right_sample >= -16'sd32764) &&
                        (i_out_word.right_sample <= 16'sd32764);

    // a full command queue means the result queue is backed up
    `SNG_ASSERT_RST(a_full_not_empty, i_clk, i_rst_n, i_full |-> !i_empty)

    // results only drain through pop
    `SNG_ASSERT_RST(a_empty_by_pop, i_clk, i_rst_n, $rose(i_empty) |-> $past(i_pop) || !$past(i_rst_n))

    // four voices at full level bound the sum
    `SNG_ASSERT_RST(a_mix_range, i_clk, i_rst_n, !i_empty |-> (l_in_range && r_in_range))

    `SNG_ASSERT_CLK(a_cfg_ready, i_clk, i_cfg_ready)

endmodule

bind square_noise_sound_generator_top sngen_checker u_sngen_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_full      (full),
    .i_empty     (empty),
    .i_pop       (pop),
    .i_out_word  (o_out_word),
    .i_cfg_ready (o_cfg_ready)
);

// ----- tb/sngen_mix_checker.sv -----
`timescale 1ns / 1ps
// Mix checker: tracks the sound generator voice state and compares every result word.
module sngen_mix_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic                 i_full,
    input  sngen_pkg::t_in_word  i_in_word,
    input  logic                 i_empty,
    input  logic                 i_pop,
    input  sngen_pkg::t_out_word i_out_word,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [1:0]           i_cfg_index,
    input  logic [3:0]           i_cfg_data,
    output int                   o_mismatches,
    output int                   o_pending,
    output int                   o_checked
);

    int gain_tab [16] = '{8191, 6507, 5168, 4105, 3261, 2590, 2057, 1642,
                          1298, 1031, 819, 650, 516, 410, 326, 0};

    logic        cfg_stereo;
    logic        cfg_out_en;
    logic [3:0]  cfg_ch_en;

    logic [3:0]  pol;
    logic [3:0]  att_l [sngen_pkg::VOICES];
    logic [3:0]  att_r [sngen_pkg::VOICES];
    logic [9:0]  tper [sngen_pkg::TONE_CH];
    logic [9:0]  tcnt [sngen_pkg::TONE_CH];
    logic [11:0] ncnt;
    logic [9:0]  nper;
    logic [15:0] nsr;
    logic [1:0]  nrate;
    logic        nwhite;
    logic        nhalf;
    logic [1:0]  lat_reg;
    logic        lat_att;

    sngen_pkg::t_out_word mix_due [$];

    function automatic void reset_voices();
        cfg_stereo = 1'b0;
        cfg_out_en = 1'b1;
        cfg_ch_en  = 4'hF;
        pol        = 4'hF;
        for (int i = 0; i < sngen_pkg::VOICES; i++) begin
            att_l[i] = 4'd15;
            att_r[i] = 4'd15;
        end
        for (int i = 0; i < sngen_pkg::TONE_CH; i++) begin
            tper[i] = '0;
            tcnt[i] = '0;
        end
        ncnt    = '0;
        nper    = '0;
        nsr     = sngen_pkg::SEED_MONO;
        nrate   = sngen_pkg::RATE_16;
        nwhite  = 1'b0;
        nhalf   = 1'b0;
        lat_reg = '0;
        lat_att = 1'b0;
        mix_due.delete();
    endfunction

    function automatic void noise_step();
        logic [9:0] span;
        int         nxt;
        logic       fb;
        if (ncnt > 12'd1) begin
            ncnt = ncnt - 12'd1;
        end else begin
            case (nrate)
                sngen_pkg::RATE_16: span = sngen_pkg::NOISE_PER_16;
                sngen_pkg::RATE_32: span = sngen_pkg::NOISE_PER_32;
                sngen_pkg::RATE_64: span = sngen_pkg::NOISE_PER_64;
                default: span = cfg_stereo ? nper : tper[sngen_pkg::REG_TONE2];
            endcase
            nxt  = int'(ncnt) - 1 + int'(span);
            ncnt = (nxt < 0) ? 12'd0 : 12'(nxt);
            nhalf = ~nhalf;
            if (nhalf) begin
                if (cfg_stereo) begin
                    fb                      = nsr[0] ^ (nsr[2] & nwhite);
                    pol[sngen_pkg::NOISE_V] = ~nsr[0];
                    nsr                     = (nsr >> 1) | (16'(fb) << 14);
                end else begin
                    pol[sngen_pkg::NOISE_V] = nsr[0];
                    fb                      = nwhite ? ~(nsr[0] ^ nsr[3]) : nsr[0];
                    nsr                     = {fb, nsr[15:1]};
                end
            end
        end
    endfunction

    function automatic void tone_step();
        for (int i = 0; i < sngen_pkg::TONE_CH; i++) begin
            if (tcnt[i] != 10'd0)
                tcnt[i] = tcnt[i] - 10'd1;
            if (tcnt[i] == 10'd0) begin
                tcnt[i] = tper[i];
                if (tper[i] != 10'd0)
                    pol[i] = ~pol[i];
            end
        end
    endfunction

    function automatic void noise_control(input logic [3:0] d, input logic [15:0] seed);
        nsr    = seed;
        nrate  = d[1:0];
        nwhite = d[2];
    endfunction

    function automatic void port_write(input logic [1:0] port, input logic [7:0] v);
        logic [3:0] d;
        logic [1:0] r;
        d = v[3:0];
        if (v[7]) begin
            lat_reg = v[6:5];
            lat_att = v[4];
        end
        r = lat_reg;
        if (v[7]) begin
            if (lat_att) begin
                if (port == sngen_pkg::MODE_RIGHT)
                    att_r[r] = d;
                else
                    att_l[r] = d;
            end else if (port == sngen_pkg::MODE_RIGHT) begin
                if (r == sngen_pkg::REG_TONE2)
                    nper = {nper[9:4], d};
                else if (r == sngen_pkg::REG_NOISE)
                    noise_control(d, sngen_pkg::SEED_STEREO);
            end else if (r != sngen_pkg::REG_NOISE) begin
                tper[r] = {tper[r][9:4], d};
            end else if (port == sngen_pkg::MODE_MONO) begin
                noise_control(d, sngen_pkg::SEED_MONO);
            end
        end else if (port == sngen_pkg::MODE_MONO) begin
            if (lat_att)
                att_l[r] = d;
            else if (r != sngen_pkg::REG_NOISE)
                tper[r] = {v[5:0], tper[r][3:0]};
            else
                noise_control(d, sngen_pkg::SEED_MONO);
        end else if (port == sngen_pkg::MODE_LEFT) begin
            if (!lat_att && r != sngen_pkg::REG_NOISE)
                tper[r] = {v[5:0], tper[r][3:0]};
        end else begin
            if (!lat_att && r == sngen_pkg::REG_TONE2)
                nper = {v[5:0], nper[3:0]};
        end
    endfunction

    function automatic sngen_pkg::t_out_word mix_now(input logic dbg);
        int                   lsum;
        int                   rsum;
        sngen_pkg::t_out_word w;
        lsum = 0;
        rsum = 0;
        if (cfg_out_en || dbg) begin
            for (int i = 0; i < sngen_pkg::VOICES; i++) begin
                if (cfg_ch_en[i]) begin
                    if (pol[i]) begin
                        lsum += gain_tab[att_l[i]];
                        rsum += gain_tab[att_r[i]];
                    end else begin
                        lsum -= gain_tab[att_l[i]];
                        rsum -= gain_tab[att_r[i]];
                    end
                end
            end
        end
        w.left_sample  = 16'(lsum);
        w.right_sample = 16'(rsum);
        return w;
    endfunction

    always @(posedge i_clk) begin
        sngen_pkg::t_out_word due;
        if (!i_rst_n) begin
            reset_voices();
        end else begin
            if (i_pop && !i_empty) begin
                if (mix_due.size() == 0) begin
                    $error("mix word popped with nothing expected");
                    o_mismatches++;
                end else begin
                    due = mix_due.pop_front();
                    o_checked++;
                    if (i_out_word.left_sample !== due.left_sample) begin
                        $error("left_sample: expected %0d, got %0d",
                               due.left_sample, i_out_word.left_sample);
                        o_mismatches++;
                    end
                    if (i_out_word.right_sample !== due.right_sample) begin
                        $error("right_sample: expected %0d, got %0d",
                               due.right_sample, i_out_word.right_sample);
                        o_mismatches++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    sngen_pkg::CFG_VARIANT: begin
                        cfg_stereo = i_cfg_data[0];
                        nsr        = cfg_stereo ? sngen_pkg::SEED_STEREO
                                                : sngen_pkg::SEED_MONO;
                    end
                    sngen_pkg::CFG_OUT_EN: cfg_out_en = i_cfg_data[0];
                    sngen_pkg::CFG_CH_EN:  cfg_ch_en  = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_push && !i_full) begin
                if (i_in_word.mode == sngen_pkg::MODE_TICK) begin
                    noise_step();
                    tone_step();
                end else begin
                    port_write(i_in_word.mode, i_in_word.data);
                end
                mix_due.push_back(mix_now(i_in_word.debug_mix));
            end
        end
        o_pending = mix_due.size();
    end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// Testbench top: clock, reset, stimulus and verdict for the sound generator.
module tb_top;

    localparam int         CLK_HALF   = 6;
    localparam int         LIMIT      = 200000;
    localparam int         PHASES     = 8;
    localparam int         PHASE_WORDS = 160;
    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam logic       KIND_PER   = 1'b0;
    localparam logic       KIND_ATT   = 1'b1;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 push;
    logic                 full;
    sngen_pkg::t_in_word  in_word;
    logic                 empty;
    logic                 pop;
    sngen_pkg::t_out_word out_word;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [1:0]           cfg_index;
    logic [3:0]           cfg_data;

    int mismatches;
    int pending;
    int checked;
    int cycle_cnt;
    int words_sent;
    int ticks_sent;
    int full_stalls;
    int hold_req;
    int pop_style;
    int burst_left;
    bit steady_send;

    square_noise_sound_generator_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_in_word   (in_word),
        .empty       (empty),
        .pop         (pop),
        .o_out_word  (out_word),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    sngen_mix_checker i_mix_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_full       (full),
        .i_in_word    (in_word),
        .i_empty      (empty),
        .i_pop        (pop),
        .i_out_word   (out_word),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("square_noise_sound_generator_top regression: fail");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && push && full)
            full_stalls++;
    end

    // result side: stall pattern per phase, plus long hold-offs on request
    initial begin
        pop = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req > 0) begin
                pop <= 1'b0;
                repeat (hold_req) @(negedge i_clk);
                hold_req = 0;
            end
            case (pop_style)
                0:       pop <= 1'b1;
                1:       pop <= ($urandom_range(0, 1) == 1);
                2:       pop <= ((cycle_cnt % 9) >= 4);
                default: pop <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    function automatic sngen_pkg::t_in_word make_word(input logic [1:0] mode,
                                                      input logic [7:0] data,
                                                      input logic dbg);
        sngen_pkg::t_in_word w;
        w.mode      = mode;
        w.data      = data;
        w.debug_mix = dbg;
        return w;
    endfunction

    function automatic logic rare_dbg();
        return ($urandom_range(0, 3) == 0);
    endfunction

    // called at a falling edge, returns at a falling edge with the word taken
    task automatic send_word(input sngen_pkg::t_in_word w);
        int gap;
        push    <= 1'b1;
        in_word <= w;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        @(negedge i_clk);
        words_sent++;
        if (w.mode == sngen_pkg::MODE_TICK)
            ticks_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 24);
            gap = steady_send ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                push <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [3:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic apply_settings(input logic stereo, input logic oe, input logic [3:0] ch_en);
        write_reg(sngen_pkg::CFG_VARIANT, {3'($urandom), stereo});
        write_reg(sngen_pkg::CFG_OUT_EN, {3'($urandom), oe});
        write_reg(sngen_pkg::CFG_CH_EN, ch_en);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        push <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic send_directed();
        send_word(make_word(sngen_pkg::MODE_TICK, 8'h00, 1'b0));
        send_word(make_word(sngen_pkg::MODE_MONO, 8'h90, 1'b0));   // tone 0 loudest, left
        send_word(make_word(sngen_pkg::MODE_RIGHT, 8'h90, 1'b0));  // tone 0 loudest, right
        send_word(make_word(sngen_pkg::MODE_LEFT, 8'hF0, 1'b0));   // noise loudest, left
        send_word(make_word(sngen_pkg::MODE_RIGHT, 8'hFF, 1'b0));  // noise silent, right
        send_word(make_word(sngen_pkg::MODE_MONO, 8'h81, 1'b0));   // tone 0 period = 1
        send_word(make_word(sngen_pkg::MODE_MONO, 8'h00, 1'b0));
        send_word(make_word(sngen_pkg::MODE_TICK, 8'hFF, 1'b0));
        send_word(make_word(sngen_pkg::MODE_TICK, 8'h00, 1'b0));
        send_word(make_word(sngen_pkg::MODE_LEFT, 8'hB5, 1'b0));
        send_word(make_word(sngen_pkg::MODE_LEFT, 8'h7F, 1'b0));   // att latched: no effect
        send_word(make_word(sngen_pkg::MODE_RIGHT, 8'hC3, 1'b0));  // noise period low
        send_word(make_word(sngen_pkg::MODE_RIGHT, 8'h3F, 1'b0));  // noise period high
        send_word(make_word(sngen_pkg::MODE_RIGHT, 8'h80, 1'b0));  // tone period on right: no effect
        send_word(make_word(sngen_pkg::MODE_RIGHT, 8'hE7, 1'b0));  // noise control, stereo seed
        send_word(make_word(sngen_pkg::MODE_LEFT, 8'hE5, 1'b0));   // noise control on left: no effect
        send_word(make_word(sngen_pkg::MODE_MONO, 8'hE4, 1'b0));   // white noise, mono seed
        send_word(make_word(sngen_pkg::MODE_MONO, 8'h03, 1'b0));   // rate follows tone 2
        repeat (3)
            send_word(make_word(sngen_pkg::MODE_TICK, 8'h00, 1'b0));  // zero period
        send_word(make_word(sngen_pkg::MODE_TICK, 8'h00, 1'b1));
        send_word(make_word(sngen_pkg::MODE_MONO, 8'hFF, 1'b1));
    endtask

    // mostly latch + data byte pairs and tick runs, some fully random words
    task automatic send_random_run(input int quota);
        int         n;
        int         pick;
        int         k;
        logic [1:0] port;
        logic [1:0] rg;
        logic       kind;
        logic [5:0] hi;
        n = 0;
        while (n < quota) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                k = $urandom_range(1, 8);
                repeat (k)
                    send_word(make_word(sngen_pkg::MODE_TICK, 8'($urandom), rare_dbg()));
                n += k;
            end else if (pick < 92) begin
                port = 2'($urandom_range(1, 3));
                rg   = 2'($urandom_range(0, 3));
                kind = ($urandom_range(0, 1) == 1) ? KIND_ATT : KIND_PER;
                send_word(make_word(port, {1'b1, rg, kind, 4'($urandom)}, rare_dbg()));
                n++;
                if ($urandom_range(0, 9) < 6) begin
                    if ($urandom_range(0, 4) == 0)
                        port = 2'($urandom_range(1, 3));
                    hi = ($urandom_range(0, 4) == 0) ? 6'($urandom) : 6'($urandom_range(0, 1));
                    send_word(make_word(port, {1'b0, 1'($urandom), hi}, rare_dbg()));
                    n++;
                end
            end else begin
                send_word(make_word(2'($urandom), 8'($urandom), 1'($urandom)));
                n++;
            end
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        push        = 1'b0;
        in_word     = '0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        hold_req    = 0;
        pop_style   = 0;
        burst_left  = 0;
        steady_send = 1'b0;
        words_sent  = 0;
        ticks_sent  = 0;
        full_stalls = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int p = 0; p < PHASES; p++) begin
            pop_style   = p % 4;
            steady_send = (p == 4);
            case (p)
                0: begin
                    write_reg(CFG_UNUSED, 4'($urandom));
                    apply_settings(1'b0, 1'b1, 4'hF);
                end
                1: apply_settings(1'b1, 1'b1, 4'hF);
                2: apply_settings(1'b0, 1'b0, 4'h0);
                3: apply_settings(1'b1, 1'b0, 4'hA);
                4: apply_settings(1'b0, 1'b1, 4'hF);
                5: apply_settings(1'b1, 1'b1, 4'($urandom));
                default: apply_settings(1'($urandom), 1'($urandom), 4'($urandom));
            endcase
            if (p == 0)
                send_directed();
            if (p == 4)
                hold_req = 80;
            send_random_run(PHASE_WORDS);
            drain();
        end

        repeat (4) @(negedge i_clk);
        $display("covered %0d words (%0d ticks) over %0d settings, mono and stereo",
                 words_sent, ticks_sent, PHASES);
        $display("checked %0d mix words; input held off by full for %0d cycles",
                 checked, full_stalls);
        if (mismatches == 0 && pending == 0)
            $display("square_noise_sound_generator_top regression: pass");
        else
            $display("square_noise_sound_generator_top regression: fail");
        $finish;
    end

endmodule
